// ===== sv/scoc_pkg.sv =====
// Shared constants for the segment versus circle obstacle checker.
// Holds the fixed field widths and action codes used by the RTL and its checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scoc_pkg;

  // Widths fixed by the interface, independent of the coordinate width.
  localparam int SLOT_BITS  = 4;
  localparam int COUNT_BITS = 5;

  // Action codes carried on the input channel.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== sv/segment_circle_obstacle_check.sv =====
// Segment versus circular obstacle collision checker, top level.
// Depends on scoc_pkg for the fixed field widths and action codes.
// Holds the obstacle table, the sequencer and the shared multiply-accumulate unit.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake            Beat carries
//  in_*      input      in_valid/in_ready    action, slot, obstacle entry, segment
//  out_*     output     out_valid/out_ready  hit flag, one beat per query
//  cfg_*     input      cfg_we (no wait)     obstacle_count
//
//  A write beat stores one table entry in the cycle it is accepted; the block is
//  ready again in the next cycle. A query first forms the segment length on the
//  shared multiplier, then for each checked obstacle runs a fetch, a prepare and
//  14 products of the shared multiplier, then one fetch that finds the end of
//  the list, and finally posts the result.
//  The query ends early at the first obstacle that is hit.
//  Reset is synchronous, active low; the table contents are not cleared.
//  A finished result waits in the output register while new beats are accepted;
//  a later query holds in its final state until that register is free.

module segment_circle_obstacle_check #(
  parameter int MAX_OBSTACLES = 16,
  parameter int COORD_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [scoc_pkg::SLOT_BITS-1:0]    in_slot,
  input  logic signed [COORD_BITS-1:0]      in_obstacle_x,
  input  logic signed [COORD_BITS-1:0]      in_obstacle_y,
  input  logic [COORD_BITS-2:0]             in_obstacle_radius,
  input  logic signed [COORD_BITS-1:0]      in_start_x,
  input  logic signed [COORD_BITS-1:0]      in_start_y,
  input  logic signed [COORD_BITS-1:0]      in_end_x,
  input  logic signed [COORD_BITS-1:0]      in_end_y,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  // Configuration port
  input  logic                              cfg_we,
  input  logic [scoc_pkg::COUNT_BITS-1:0]   cfg_obstacle_count
);

  import scoc_pkg::*;

  // Table index and obstacle counter widths.
  localparam int IDXW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNTW = $clog2(MAX_OBSTACLES + 1);
  localparam int SXW  = SLOT_BITS + IDXW;
  localparam int CXW  = COUNT_BITS + CNTW;
  // Arithmetic widths. Differences of two coordinates need one extra bit.
  // Squared lengths and the dot product fit in SQW signed bits; their
  // unsigned magnitudes split into two halves of HK bits each.
  localparam int RW   = COORD_BITS - 1;
  localparam int DW   = COORD_BITS + 1;
  localparam int HK   = COORD_BITS + 1;
  localparam int MW   = COORD_BITS + 2;
  localparam int PW   = 2 * MW;
  localparam int SQW  = 2 * COORD_BITS + 3;
  localparam int AW   = 4 * COORD_BITS + 5;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALC  = 5'b00010,
    S_FETCH = 5'b00100,
    S_PREP  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Microprogram of the shared unit. The first two steps run once per query
  // and form the squared segment length; the rest run once per obstacle.
  typedef enum logic [3:0] {
    ST_A_X, ST_A_Y,
    ST_FF_X, ST_FF_Y, ST_GG_X, ST_GG_Y, ST_R2,
    ST_P_X, ST_P_Y,
    ST_QQ_HH, ST_QQ_HL, ST_QQ_LL,
    ST_AC_HH, ST_AC_HL, ST_AC_LH, ST_AC_LL
  } step_t;

  typedef enum logic [1:0] {
    SH_0, SH_K, SH_K1, SH_2K
  } shift_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [RW-1:0]                r;
  } entry_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                  state_r;
  step_t                   step_r;
  logic                    phase_r;
  logic [CNTW-1:0]         k_r;
  logic [CNTW-1:0]         limit_r;
  logic                    hit_r;
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [COUNT_BITS-1:0]   obstacle_count_r;

  logic signed [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [DW-1:0]    dx_r, dy_r, fx_r, fy_r, gx_r, gy_r;
  logic [RW-1:0]           r_r;
  logic signed [SQW-1:0]   a_r, ff_r, gg_r, r2_r, q_r, c_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [AW-1:0]    acc_r;

  entry_t                  mem [MAX_OBSTACLES];
  entry_t                  rd_r;

  // ---------------------------------------------------------------------------
  // Handshake and table write decode
  // ---------------------------------------------------------------------------
  logic            in_fire;
  logic            wr_en;
  logic [SXW-1:0]  slot_ext;
  logic            slot_ok;
  logic [CXW-1:0]  count_ext;
  logic [CXW-1:0]  count_lim;
  entry_t          wr_entry;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_ext  = {{IDXW{1'b0}}, in_slot};
  // Writes to slots past the end of the table are dropped.
  assign slot_ok   = (slot_ext < SXW'(MAX_OBSTACLES));
  assign wr_en     = in_fire && (in_action == ACT_WRITE) && slot_ok;
  assign wr_entry  = '{x: in_obstacle_x, y: in_obstacle_y, r: in_obstacle_radius};

  // A programmed count larger than the table is treated as the full table.
  assign count_ext = {{CNTW{1'b0}}, obstacle_count_r};
  assign count_lim = (count_ext > CXW'(MAX_OBSTACLES)) ? CXW'(MAX_OBSTACLES) : count_ext;

  // Obstacle table. The read port follows the obstacle index every cycle, so
  // the entry for k_r is ready in the cycle after k_r settles.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_ext[IDXW-1:0]] <= wr_entry;
    end
    rd_r <= mem[k_r[IDXW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-accumulate unit: operand selection per microstep
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] mul_a, mul_b;
  shift_t               op_shift;
  logic                 op_neg;
  logic                 op_clr;

  logic [HK-1:0] q_lo, q_hi, a_lo, a_hi, c_lo, c_hi;
  assign q_lo = q_r[HK-1:0];
  assign q_hi = q_r[2*HK-1:HK];
  assign a_lo = a_r[HK-1:0];
  assign a_hi = a_r[2*HK-1:HK];
  assign c_lo = c_r[HK-1:0];
  assign c_hi = c_r[2*HK-1:HK];

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    op_shift = SH_0;
    op_neg   = 1'b0;
    op_clr   = 1'b0;
    unique case (step_r)
      ST_A_X: begin
        mul_a = {dx_r[DW-1], dx_r}; mul_b = {dx_r[DW-1], dx_r}; op_clr = 1'b1;
      end
      ST_A_Y: begin
        mul_a = {dy_r[DW-1], dy_r}; mul_b = {dy_r[DW-1], dy_r};
      end
      ST_FF_X: begin
        mul_a = {fx_r[DW-1], fx_r}; mul_b = {fx_r[DW-1], fx_r}; op_clr = 1'b1;
      end
      ST_FF_Y: begin
        mul_a = {fy_r[DW-1], fy_r}; mul_b = {fy_r[DW-1], fy_r};
      end
      ST_GG_X: begin
        mul_a = {gx_r[DW-1], gx_r}; mul_b = {gx_r[DW-1], gx_r}; op_clr = 1'b1;
      end
      ST_GG_Y: begin
        mul_a = {gy_r[DW-1], gy_r}; mul_b = {gy_r[DW-1], gy_r};
      end
      ST_R2: begin
        mul_a = {{(MW-RW){1'b0}}, r_r}; mul_b = {{(MW-RW){1'b0}}, r_r}; op_clr = 1'b1;
      end
      // The dot product is accumulated negated, so q = -(d.f) directly.
      ST_P_X: begin
        mul_a = {dx_r[DW-1], dx_r}; mul_b = {fx_r[DW-1], fx_r};
        op_clr = 1'b1; op_neg = 1'b1;
      end
      ST_P_Y: begin
        mul_a = {dy_r[DW-1], dy_r}; mul_b = {fy_r[DW-1], fy_r}; op_neg = 1'b1;
      end
      // q*q from halves; the cross term appears twice, hence one extra shift.
      ST_QQ_HH: begin
        mul_a = {1'b0, q_hi}; mul_b = {1'b0, q_hi}; op_shift = SH_2K; op_clr = 1'b1;
      end
      ST_QQ_HL: begin
        mul_a = {1'b0, q_hi}; mul_b = {1'b0, q_lo}; op_shift = SH_K1;
      end
      ST_QQ_LL: begin
        mul_a = {1'b0, q_lo}; mul_b = {1'b0, q_lo};
      end
      // a*c is subtracted, leaving q*q - a*c in the accumulator.
      ST_AC_HH: begin
        mul_a = {1'b0, a_hi}; mul_b = {1'b0, c_hi}; op_shift = SH_2K; op_neg = 1'b1;
      end
      ST_AC_HL: begin
        mul_a = {1'b0, a_hi}; mul_b = {1'b0, c_lo}; op_shift = SH_K; op_neg = 1'b1;
      end
      ST_AC_LH: begin
        mul_a = {1'b0, a_lo}; mul_b = {1'b0, c_hi}; op_shift = SH_K; op_neg = 1'b1;
      end
      ST_AC_LL: begin
        mul_a = {1'b0, a_lo}; mul_b = {1'b0, c_lo}; op_neg = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Accumulate stage: the registered product, shifted into place and added to
  // or subtracted from the running sum.
  logic signed [AW-1:0] prod_ext, prod_sh, acc_base, acc_nxt;

  assign prod_ext = {{(AW-PW){prod_r[PW-1]}}, prod_r};

  always_comb begin
    case (op_shift)
      SH_K:    prod_sh = prod_ext <<< HK;
      SH_K1:   prod_sh = prod_ext <<< (HK + 1);
      SH_2K:   prod_sh = prod_ext <<< (2 * HK);
      default: prod_sh = prod_ext;
    endcase
  end

  assign acc_base = op_clr ? '0 : acc_r;
  assign acc_nxt  = op_neg ? (acc_base - prod_sh) : (acc_base + prod_sh);

  // Decisions taken from registered quantities at the start of a step.
  logic end_inside;
  logic q_out_of_range;

  assign end_inside     = (ff_r <= r2_r) || (gg_r <= r2_r);
  assign q_out_of_range = q_r[SQW-1] || (q_r > a_r);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      step_r           <= ST_A_X;
      phase_r          <= 1'b0;
      k_r              <= '0;
      limit_r          <= '0;
      hit_r            <= 1'b0;
      out_valid_r      <= 1'b0;
      obstacle_count_r <= '0;
    end else begin
      if (cfg_we) begin
        obstacle_count_r <= cfg_obstacle_count;
      end

      // In the final state the output register is loaded below instead.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && (in_action == ACT_QUERY)) begin
            state_r <= S_CALC;
            step_r  <= ST_A_X;
            phase_r <= 1'b0;
            k_r     <= '0;
            limit_r <= count_lim[CNTW-1:0];
            hit_r   <= 1'b0;
          end
        end

        S_CALC: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            if (step_r == ST_P_X) begin
              // Either endpoint inside the circle is a hit; a zero-length
              // segment can hit no other way.
              if (end_inside) begin
                hit_r   <= 1'b1;
                state_r <= S_DONE;
              end else if (a_r == '0) begin
                k_r     <= k_r + 1'b1;
                state_r <= S_FETCH;
              end
            end else if (step_r == ST_QQ_HH) begin
              // The closest approach must fall between the endpoints.
              if (q_out_of_range) begin
                k_r     <= k_r + 1'b1;
                state_r <= S_FETCH;
              end
            end
          end else begin
            phase_r <= 1'b0;
            step_r  <= step_t'(step_r + 4'd1);
            case (step_r)
              ST_A_Y: begin
                a_r     <= acc_nxt[SQW-1:0];
                state_r <= S_FETCH;
              end
              ST_FF_Y: ff_r <= acc_nxt[SQW-1:0];
              ST_GG_Y: gg_r <= acc_nxt[SQW-1:0];
              ST_R2:   r2_r <= acc_nxt[SQW-1:0];
              ST_P_Y: begin
                q_r <= acc_nxt[SQW-1:0];
                c_r <= ff_r - r2_r;
              end
              ST_AC_LL: begin
                if (!acc_nxt[AW-1]) begin
                  hit_r   <= 1'b1;
                  state_r <= S_DONE;
                end else begin
                  k_r     <= k_r + 1'b1;
                  state_r <= S_FETCH;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_FETCH: begin
          if (k_r == limit_r) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_PREP;
          end
        end

        S_PREP: begin
          step_r  <= ST_FF_X;
          phase_r <= 1'b0;
          state_r <= S_CALC;
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_fire && (in_action == ACT_QUERY)) begin
      sx_r <= in_start_x;
      sy_r <= in_start_y;
      ex_r <= in_end_x;
      ey_r <= in_end_y;
      dx_r <= {in_end_x[COORD_BITS-1], in_end_x} - {in_start_x[COORD_BITS-1], in_start_x};
      dy_r <= {in_end_y[COORD_BITS-1], in_end_y} - {in_start_y[COORD_BITS-1], in_start_y};
    end

    if (state_r == S_PREP) begin
      fx_r <= {sx_r[COORD_BITS-1], sx_r} - {rd_r.x[COORD_BITS-1], rd_r.x};
      fy_r <= {sy_r[COORD_BITS-1], sy_r} - {rd_r.y[COORD_BITS-1], rd_r.y};
      gx_r <= {ex_r[COORD_BITS-1], ex_r} - {rd_r.x[COORD_BITS-1], rd_r.x};
      gy_r <= {ey_r[COORD_BITS-1], ey_r} - {rd_r.y[COORD_BITS-1], rd_r.y};
      r_r  <= rd_r.r;
    end

    if ((state_r == S_CALC) && !phase_r) begin
      prod_r <= mul_a * mul_b;
    end

    if ((state_r == S_CALC) && phase_r) begin
      acc_r <= acc_nxt;
    end

    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_hit_r <= hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

`default_nettype wire

// ===== sv/scoc_checker.sv =====
// Port-level checker for the segment versus circle obstacle checker.
// Depends on scoc_pkg for the action codes; bound to the top level below.
`timescale 1ns / 1ps
`default_nettype none

module scoc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  import scoc_pkg::*;

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("result beat changed while stalled");

  // A table write never produces a result beat.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_WRITE) && !out_valid |=> !out_valid)
    else $error("result beat appeared after a table write");

  // A query keeps the block busy for at least the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_QUERY) |=> !in_ready)
    else $error("input ready right after a query beat");

  // A new result only comes out of a busy period.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat appeared while the block was idle");

endmodule

bind segment_circle_obstacle_check scoc_checker u_scoc_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for segment_circle_obstacle_check.
// Depends on scoc_pkg and the RTL top level; needs no other files.
// A directed table and shaped random traffic are checked against an internal predictor.
`timescale 1ns / 1ps

module tb_top;
  import scoc_pkg::*;

  localparam int SLOTS           = 16;
  localparam int CW              = 16;
  // Marks a directed row whose hit flag comes from the predictor.
  localparam int PREDICT         = -1;
  // Marks a directed row that leaves the obstacle count as it is.
  localparam int KEEP_COUNT      = -1;
  // Margin for a write beat to settle; it covers the need many times over.
  localparam int SETTLE_CYCLES   = 40;
  // Longer than the slowest query, which checks every table entry.
  localparam int TAIL_CYCLES     = 600;
  localparam int DRAIN_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 3000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 170;

  typedef logic signed [CW-1:0] coord_t;

  // One input beat, every field present whatever the action.
  typedef struct packed {
    logic                 action;
    logic [SLOT_BITS-1:0] slot;
    coord_t               ox;
    coord_t               oy;
    logic [CW-2:0]        radius;
    coord_t               sx;
    coord_t               sy;
    coord_t               ex;
    coord_t               ey;
  } beat_t;

  // One row of the directed table.
  typedef struct {
    int    new_count;
    int    typed_hit;
    beat_t b;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_action;
  logic [SLOT_BITS-1:0]  in_slot;
  coord_t                in_obstacle_x;
  coord_t                in_obstacle_y;
  logic [CW-2:0]         in_obstacle_radius;
  coord_t                in_start_x;
  coord_t                in_start_y;
  coord_t                in_end_x;
  coord_t                in_end_y;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_hit;
  logic                  cfg_we;
  logic [COUNT_BITS-1:0] cfg_obstacle_count;

  // Our own copy of the obstacle table and of the count register.
  coord_t        ctr_x   [SLOTS];
  coord_t        ctr_y   [SLOTS];
  logic [CW-2:0] rad_tab [SLOTS];
  int            obst_count = 0;

  // Hit flags still owed by the block, oldest first.
  bit hit_q[$];
  int mismatches = 0;

  // Idle rates in percent, one for the sender and one for the receiver.
  int src_idle_pct  = 7;
  int sink_idle_pct = 7;
  // Set by the sender to make the receiver hold off for a long stretch.
  bit sink_hold_req = 1'b0;

  // Obstacle counts for the random phases; both extremes and the saturating
  // values above the table size are among them.
  int phase_count [PHASES] = '{16, 31, 1, 0, 17, 9, 16, 4, 31, 13};

  segment_circle_obstacle_check uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_slot            (in_slot),
    .in_obstacle_x      (in_obstacle_x),
    .in_obstacle_y      (in_obstacle_y),
    .in_obstacle_radius (in_obstacle_radius),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .cfg_we             (cfg_we),
    .cfg_obstacle_count (cfg_obstacle_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Does the segment touch table entry k? Endpoints inside the circle count as
  // a touch. Otherwise the chord test is done exactly: with d = end - start,
  // f = start - centre, a = d.d, p = d.f and c = f.f - r^2, a root lies in
  // [0, 1] only when a > 0, -a <= p <= 0 and p^2 >= a * c. The products need
  // well over 64 bits, so they are formed at 128.
  function automatic bit circle_touched(input coord_t sx, input coord_t sy,
                                        input coord_t ex, input coord_t ey, input int k);
    longint cx, cy, r2, fx, fy, gx, gy, dx, dy, ff, gg, a, p;
    logic signed [127:0] lhs, rhs;
    cx = longint'(ctr_x[k[SLOT_BITS-1:0]]);
    cy = longint'(ctr_y[k[SLOT_BITS-1:0]]);
    r2 = longint'(rad_tab[k[SLOT_BITS-1:0]]) * longint'(rad_tab[k[SLOT_BITS-1:0]]);
    fx = longint'(sx) - cx;
    fy = longint'(sy) - cy;
    gx = longint'(ex) - cx;
    gy = longint'(ey) - cy;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    ff = fx * fx + fy * fy;
    gg = gx * gx + gy * gy;
    if (ff <= r2 || gg <= r2) return 1'b1;
    a = dx * dx + dy * dy;
    // A zero-length segment can only hit through its endpoint.
    if (a == 0) return 1'b0;
    p = dx * fx + dy * fy;
    if (p > 0 || p < -a) return 1'b0;
    lhs = 128'(p) * 128'(p);
    rhs = 128'(a) * 128'(ff - r2);
    return lhs >= rhs;
  endfunction

  // Hit flag of a query: any of the first obstacle_count entries, where a
  // count above the table size means the whole table.
  function automatic bit segment_hits(input coord_t sx, input coord_t sy,
                                      input coord_t ex, input coord_t ey);
    int n;
    n = (obst_count > SLOTS) ? SLOTS : obst_count;
    for (int k = 0; k < n; k++) begin
      if (circle_touched(sx, sy, ex, ey, k)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[CW-1:0];
  endfunction

  function automatic row_t mk_row(input int new_count, input int typed_hit, input logic action,
                                  input int slot, input int ox, input int oy, input int radius,
                                  input int sx, input int sy, input int ex, input int ey);
    row_t r;
    r.new_count = new_count;
    r.typed_hit = typed_hit;
    r.b.action  = action;
    r.b.slot    = slot[SLOT_BITS-1:0];
    r.b.ox      = ox[CW-1:0];
    r.b.oy      = oy[CW-1:0];
    r.b.radius  = radius[CW-2:0];
    r.b.sx      = sx[CW-1:0];
    r.b.sy      = sy[CW-1:0];
    r.b.ex      = ex[CW-1:0];
    r.b.ey      = ey[CW-1:0];
    return r;
  endfunction

  // Random beat. Fields that the action does not use are always random. Most
  // queries are built around one of the checked obstacles, since segments
  // drawn over the whole plane rarely come near the chord test's boundaries.
  function automatic beat_t random_beat();
    beat_t  b;
    int     k, n, mode;
    longint cx, cy, r, span, off, l1, l2;
    b.action = ($urandom_range(99) < 25) ? ACT_WRITE : ACT_QUERY;
    b.slot   = SLOT_BITS'($urandom_range(SLOTS - 1));
    b.ox     = coord_t'($urandom);
    b.oy     = coord_t'($urandom);
    // Small radii keep circles in reach of the shaped segments below.
    b.radius = ($urandom_range(99) < 70) ? 15'($urandom_range(1023)) : 15'($urandom);
    b.sx     = coord_t'($urandom);
    b.sy     = coord_t'($urandom);
    b.ex     = coord_t'($urandom);
    b.ey     = coord_t'($urandom);
    if (b.action == ACT_WRITE) return b;

    n = (obst_count > SLOTS) ? SLOTS : obst_count;
    k = (n == 0) ? $urandom_range(SLOTS - 1) : $urandom_range(n - 1);
    cx = longint'(ctr_x[k[SLOT_BITS-1:0]]);
    cy = longint'(ctr_y[k[SLOT_BITS-1:0]]);
    r = longint'(rad_tab[k[SLOT_BITS-1:0]]);
    mode = $urandom_range(99);
    if (mode < 20) begin
      // Segment anywhere in the plane.
    end else if (mode < 60) begin
      // Both endpoints within a few radii of the centre.
      span = 3 * r + 16;
      b.sx = clamp_coord(cx + longint'($urandom_range(32'(2 * span))) - span);
      b.sy = clamp_coord(cy + longint'($urandom_range(32'(2 * span))) - span);
      b.ex = clamp_coord(cx + longint'($urandom_range(32'(2 * span))) - span);
      b.ey = clamp_coord(cy + longint'($urandom_range(32'(2 * span))) - span);
    end else if (mode < 85) begin
      // Axis-parallel line one unit inside, on, or one unit outside the
      // tangent. The extent along the line varies, so the circle may lie
      // beyond either end of the segment.
      off = r + longint'($urandom_range(2)) - 1;
      if ($urandom_range(1) == 1) off = -off;
      l1 = longint'($urandom_range(32'(2 * r + 250))) - (r + 50);
      l2 = longint'($urandom_range(32'(2 * r + 250))) - (r + 50);
      if ($urandom_range(1) == 1) begin
        b.sx = clamp_coord(cx - l1);
        b.ex = clamp_coord(cx + l2);
        b.sy = clamp_coord(cy + off);
        b.ey = b.sy;
      end else begin
        b.sy = clamp_coord(cy - l1);
        b.ey = clamp_coord(cy + l2);
        b.sx = clamp_coord(cx + off);
        b.ex = b.sx;
      end
    end else begin
      // Zero-length segment right at the rim.
      off = r + longint'($urandom_range(2)) - 1;
      if ($urandom_range(1) == 1) begin
        b.sx = clamp_coord(cx + off);
        b.sy = clamp_coord(cy);
      end else begin
        b.sx = clamp_coord(cx);
        b.sy = clamp_coord(cy - off);
      end
      b.ex = b.sx;
      b.ey = b.sy;
    end
    return b;
  endfunction

  // Offers one beat and waits for the handshake. Inputs change only at a
  // rising edge, and in_ready is sampled at the edge itself, so the handshake
  // is seen exactly as the block sees it. Valid is never dropped while a beat
  // is on offer; idle cycles come only before the offer.
  task automatic send_beat(input beat_t b, input int typed_hit);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= b.action;
    in_slot            <= b.slot;
    in_obstacle_x      <= b.ox;
    in_obstacle_y      <= b.oy;
    in_obstacle_radius <= b.radius;
    in_start_x         <= b.sx;
    in_start_y         <= b.sy;
    in_end_x           <= b.ex;
    in_end_y           <= b.ey;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    // The beat was taken at this edge: bring the predictor along.
    if (b.action == ACT_WRITE) begin
      ctr_x[b.slot]   = b.ox;
      ctr_y[b.slot]   = b.oy;
      rad_tab[b.slot] = b.radius;
    end else if (typed_hit != PREDICT) begin
      hit_q.push_back(typed_hit[0]);
    end else begin
      hit_q.push_back(segment_hits(b.sx, b.sy, b.ex, b.ey));
    end
  endtask

  // The count register may only change while the block is idle: stop
  // offering beats, wait for every owed result, let a write beat settle,
  // then write the register for one cycle.
  task automatic set_obstacle_count(input int value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (hit_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we             <= 1'b1;
    cfg_obstacle_count <= value[COUNT_BITS-1:0];
    @(posedge clk);
    cfg_we     <= 1'b0;
    obst_count = value;
  endtask

  // Result checker: every beat on the result channel must match the oldest
  // owed hit flag.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (hit_q.size() == 0) begin
        $error("hit result %0b arrived with no query waiting", out_hit);
        mismatches++;
      end else begin
        if (out_hit !== hit_q[0]) begin
          $error("hit: expected %0b, got %0b", hit_q[0], out_hit);
          mismatches++;
        end
        void'(hit_q.pop_front());
      end
    end
  end

  // Receiver. It stalls at random, and when asked it holds off for a long
  // stretch so the finished result blocks the next query and the input
  // channel backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        hold_left     = HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Sender and run control.
  initial begin
    row_t  dir_rows[$];
    beat_t b;
    int    waited;

    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_action          <= ACT_WRITE;
    in_slot            <= '0;
    in_obstacle_x      <= '0;
    in_obstacle_y      <= '0;
    in_obstacle_radius <= '0;
    in_start_x         <= '0;
    in_start_y         <= '0;
    in_end_x           <= '0;
    in_end_y           <= '0;
    cfg_we             <= 1'b0;
    cfg_obstacle_count <= '0;

    // Directed table. The first two queries run on the count left by reset,
    // which is zero, so nothing can be hit. Entries are written before any
    // count reaches them, so no query ever looks at an unwritten entry.
    dir_rows.push_back(mk_row(KEEP_COUNT, 0, ACT_QUERY, 0, 0, 0, 0,
                              -32768, -32768, 32767, 32767));
    dir_rows.push_back(mk_row(KEEP_COUNT, 0, ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_WRITE, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_WRITE, 1, 32767, -32768, 32767,
                              0, 0, 0, 0));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_WRITE, 2, -32768, 32767, 0,
                              0, 0, 0, 0));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_WRITE, 3, 1000, 1000, 100,
                              0, 0, 0, 0));
    // A point circle at the origin: a zero-length segment on it hits, one
    // unit off it misses.
    dir_rows.push_back(mk_row(1, 1, ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(KEEP_COUNT, 0, ACT_QUERY, 0, 0, 0, 0, 1, 0, 1, 0));
    // Through the point circle, moving away from it, and stopping short.
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_QUERY, 0, 0, 0, 0, -5, -5, 5, 5));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_QUERY, 0, 0, 0, 0, 5, 5, 10, 10));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_QUERY, 0, 0, 0, 0,
                              -20, -20, -10, -10));
    // Exact tangent to the circle at (1000, 1000) and one unit clear of it.
    dir_rows.push_back(mk_row(4, PREDICT, ACT_QUERY, 0, 0, 0, 0, 900, 1100, 1100, 1100));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_QUERY, 0, 0, 0, 0,
                              900, 1101, 1100, 1101));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_QUERY, 0, 0, 0, 0,
                              -32768, -32768, 32767, 32767));
    dir_rows.push_back(mk_row(KEEP_COUNT, 1, ACT_QUERY, 0, 0, 0, 0,
                              -32768, 32767, -32768, 32767));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_QUERY, 0, 0, 0, 0,
                              32767, 32767, 32767, 32767));
    // Largest radius, and the last slot.
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_WRITE, 3, -1, -1, 32767,
                              0, 0, 0, 0));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_WRITE, 15, -32768, -32768, 32767,
                              0, 0, 0, 0));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_QUERY, 0, 0, 0, 0,
                              32767, 32767, 32767, 32767));
    dir_rows.push_back(mk_row(KEEP_COUNT, PREDICT, ACT_QUERY, 0, 0, 0, 0,
                              -32768, 0, 32767, 0));
    dir_rows.push_back(mk_row(0, 0, ACT_QUERY, 0, 0, 0, 0, -1, -1, -1, -1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].new_count != KEEP_COUNT) set_obstacle_count(dir_rows[i].new_count);
      send_beat(dir_rows[i].b, dir_rows[i].typed_hit);
    end

    // Fill the whole table so that every count is legal from here on.
    for (int k = 0; k < SLOTS; k++) begin
      b        = random_beat();
      b.action = ACT_WRITE;
      b.slot   = SLOT_BITS'(k);
      send_beat(b, PREDICT);
    end

    // Random phases. Each starts with the sender waiting for every owed
    // result, then a new count. One phase runs with no idling on either side,
    // and one has the receiver hold off long enough to back up the input.
    for (int ph = 0; ph < PHASES; ph++) begin
      set_obstacle_count(phase_count[ph]);
      src_idle_pct  = (ph == 5) ? 0 : 7;
      sink_idle_pct = (ph == 5) ? 0 : 7;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 1 && i == 20) sink_hold_req = 1'b1;
        send_beat(random_beat(), PREDICT);
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (hit_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // Then wait on, to catch any result the block should not send.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (hit_q.size() != 0) begin
      $error("%0d hit results never arrived", hit_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #50000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/scoc_pkg.sv
sv/segment_circle_obstacle_check.sv
sv/scoc_checker.sv
sim/tb_top.sv
